FILE: hw/rtl/pet_pkg.sv
// ----------------------------------------------------------------------------
// Periodic event timer bank package
// Request and response codes and the transaction structs shared by the bank.
// ----------------------------------------------------------------------------
package pet_pkg;

  localparam int COUNT_W = 16;
  localparam int SUM_W   = COUNT_W + 1;

  typedef enum logic [1:0] {
    REQ_TICK       = 2'd0,
    REQ_ADD        = 2'd1,
    REQ_SET_ENABLE = 2'd2,
    REQ_IGNORE     = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_ZERO_INTERVAL = 3'd1,
    ST_DUPLICATE     = 3'd2,
    ST_FULL          = 3'd3,
    ST_NOT_FOUND     = 3'd4
  } status_t;

  typedef struct packed {
    req_type_t            req_type;
    logic [7:0]           event_id;
    logic [COUNT_W-1:0]   interval;
    logic                 enable;
  } pet_req_t;

  typedef struct packed {
    status_t    status;
    logic [2:0] slot_index;
    logic [7:0] fire_mask;
  } pet_rsp_t;

endpackage

FILE: hw/rtl/pet_if.sv
// ----------------------------------------------------------------------------
// Periodic event timer bank channels
// Valid/ready request and response channels of the timer bank.
// ----------------------------------------------------------------------------
interface pet_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  event_id;
  logic [15:0] interval;
  logic        enable;

  modport source (output valid, req_type, event_id, interval, enable, input ready);
  modport sink   (input valid, req_type, event_id, interval, enable, output ready);
endinterface

interface pet_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] slot_index;
  logic [7:0] fire_mask;

  modport source (output valid, status, slot_index, fire_mask, input ready);
  modport sink   (input valid, status, slot_index, fire_mask, output ready);
endinterface

FILE: hw/rtl/periodic_event_timer_bank_top.sv
// ----------------------------------------------------------------------------
// Periodic event timer bank
// Bank of periodic event slots with add, set-enable and tick requests.
// ----------------------------------------------------------------------------
// The bank takes one request transaction per cycle when the response side is
// not stalled and returns exactly one response transaction for each, through
// the input register and then the output register. A request is held in the
// input register and is decoded against all slots at once in the slot store,
// whose compare and update logic sets the figure of one request per cycle. A
// stalled response is held in the output register while the input register
// can still take one more request. Reset empties the table; no clearing pass.
module periodic_event_timer_bank_top #(
  parameter int NUM_SLOTS = 8,
  parameter int TICK_STEP = 10
) (
  input logic       clk,
  input logic       rst,
  pet_req_if.sink   req,
  pet_rsp_if.source rsp
);
  import pet_pkg::*;

  logic     stage_valid;
  pet_req_t stage_req;
  logic     out_valid;
  pet_rsp_t out_rsp;
  pet_rsp_t bank_rsp;
  logic     out_load;
  logic     advance;
  logic     accept;

  assign out_load  = !out_valid || rsp.ready;
  assign advance   = stage_valid && out_load;
  assign req.ready = !stage_valid || out_load;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept || (stage_valid && !advance);
    end
    if (accept) begin
      stage_req.req_type <= req_type_t'(req.req_type);
      stage_req.event_id <= req.event_id;
      stage_req.interval <= req.interval;
      stage_req.enable   <= req.enable;
    end
  end

  pet_slots #(
    .NUM_SLOTS(NUM_SLOTS),
    .TICK_STEP(TICK_STEP)
  ) u_slots (
    .clk   (clk),
    .rst   (rst),
    .commit(advance),
    .req   (stage_req),
    .rsp   (bank_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= stage_valid;
    end
    if (advance) begin
      out_rsp <= bank_rsp;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_rsp.status;
  assign rsp.slot_index = out_rsp.slot_index;
  assign rsp.fire_mask  = out_rsp.fire_mask;

endmodule

FILE: hw/rtl/pet_slots.sv
// ----------------------------------------------------------------------------
// Periodic event timer slot store
// Holds the slots and decodes one request against all of them in parallel.
// ----------------------------------------------------------------------------
module pet_slots #(
  parameter int NUM_SLOTS = 8,
  parameter int TICK_STEP = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              commit,
  input  pet_pkg::pet_req_t req,
  output pet_pkg::pet_rsp_t rsp
);
  import pet_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic                 slot_valid   [NUM_SLOTS];
  logic [7:0]           slot_event   [NUM_SLOTS];
  logic [COUNT_W-1:0]   slot_period  [NUM_SLOTS];
  logic                 slot_enabled [NUM_SLOTS];
  logic [COUNT_W-1:0]   slot_count   [NUM_SLOTS];

  logic [SUM_W-1:0]     sum          [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] fire;
  logic                 found;
  logic [SLOT_W-1:0]    match_idx;
  logic                 has_free;
  logic [SLOT_W-1:0]    free_idx;
  logic                 add_ok;
  logic                 set_ok;
  logic [SLOT_W+2:0]    idx_ext;
  logic [NUM_SLOTS+7:0] fire_ext;

  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    has_free  = 1'b0;
    free_idx  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      sum[i]    = {1'b0, slot_count[i]} + SUM_W'(TICK_STEP);
      active[i] = slot_valid[i] && slot_enabled[i];
      fire[i]   = active[i] && (sum[i] >= {1'b0, slot_period[i]});
      if (slot_valid[i] && slot_event[i] == req.event_id) begin
        found     = 1'b1;
        match_idx = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        has_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rsp      = '0;
    add_ok   = 1'b0;
    set_ok   = 1'b0;
    idx_ext  = '0;
    fire_ext = '0;
    unique case (req.req_type)
      REQ_TICK: begin
        fire_ext      = {8'b0, fire};
        rsp.fire_mask = fire_ext[7:0];
      end
      REQ_ADD: begin
        if (req.interval == '0) begin
          rsp.status = ST_ZERO_INTERVAL;
        end else if (found) begin
          rsp.status = ST_DUPLICATE;
        end else if (!has_free) begin
          rsp.status = ST_FULL;
        end else begin
          add_ok         = 1'b1;
          idx_ext        = {3'b0, free_idx};
          rsp.slot_index = idx_ext[2:0];
        end
      end
      REQ_SET_ENABLE: begin
        if (found) begin
          set_ok         = 1'b1;
          idx_ext        = {3'b0, match_idx};
          rsp.slot_index = idx_ext[2:0];
        end else begin
          rsp.status = ST_NOT_FOUND;
        end
      end
      REQ_IGNORE: begin
        rsp = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (rst) begin
        slot_valid[i] <= 1'b0;
      end else if (commit) begin
        if (req.req_type == REQ_TICK && active[i]) begin
          slot_count[i] <= fire[i] ? '0 : sum[i][COUNT_W-1:0];
        end
        if (add_ok && free_idx == SLOT_W'(i)) begin
          slot_valid[i]   <= 1'b1;
          slot_event[i]   <= req.event_id;
          slot_period[i]  <= req.interval;
          slot_enabled[i] <= req.enable;
          slot_count[i]   <= '0;
        end
        if (set_ok && match_idx == SLOT_W'(i)) begin
          slot_enabled[i] <= req.enable;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/pet_checker.sv
// ----------------------------------------------------------------------------
// Periodic event timer bank checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module pet_checker (
  input logic       clk,
  input logic       rst,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] status,
  input logic [2:0] slot_index,
  input logic [7:0] fire_mask
);
  import pet_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(slot_index)
      && $stable(fire_mask))
    else $error("Stalled response transaction changed.");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("Response valid directly after reset.");

  a_fire_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> fire_mask == '0 && slot_index == '0)
    else $error("Rejected request carries a slot or fire mask.");

  a_fire_no_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && fire_mask != '0 |-> slot_index == '0)
    else $error("Tick response carries a slot index.");

endmodule

bind periodic_event_timer_bank_top pet_checker u_pet_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .slot_index(rsp.slot_index),
  .fire_mask (rsp.fire_mask)
);
